[rtl/corner_nms_top_k_select_macros.svh]
// assertion macros for the corner suppression and top-k block
// used by the top level; no other dependencies
`ifndef CORNER_NMS_TOP_K_SELECT_MACROS_SVH
`define CORNER_NMS_TOP_K_SELECT_MACROS_SVH
`ifndef SYNTHESIS
// condition that must hold at every edge outside reset
`define CNMS_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("corner block check failed");
// trigger one cycle, consequence the next
`define CNMS_ASSERT_NEXT(label, trig, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error("corner block sequence check failed");
`else
`define CNMS_ASSERT_ALWAYS(label, cond)
`define CNMS_ASSERT_NEXT(label, trig, cons)
`endif
`endif

[rtl/cnms_pkg.sv]
// shared constants and types for the corner suppression and top-k block
// no dependencies
package cnms_pkg;
   localparam int VALUE_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int DEF_MAX_WIDTH = 2048;
   localparam int DEF_MAX_HEIGHT = 2048;
   localparam int DEF_LIST_DEPTH = 64;
   localparam int DEF_RESPONSE_BITS = 32;
   localparam logic [11:0] RST_WIDTH = 12'd640;
   localparam logic [11:0] RST_HEIGHT = 12'd480;
   // register indexes
   localparam logic [2:0] REG_WIDTH = 3'd0;
   localparam logic [2:0] REG_HEIGHT = 3'd1;
   localparam logic [2:0] REG_THRESH = 3'd2;
   localparam logic [2:0] REG_MARGIN = 3'd3;
   localparam logic [2:0] REG_LIMIT = 3'd4;
   // command broadcast along the list chain
   typedef struct packed {
      logic clear;
      logic pop;
      logic insert;
   } cell_cmd_type;
endpackage

[rtl/corner_nms_top_k_select.sv]
// top level: register port, raster counters, corner list chain and result sequencer
// depends on cnms_pkg, cnms_window, cnms_cell and the macro header
//
// Within a frame one response word is taken every clock. Each word runs through
// a four-stage pipe (line store read, window shift, 3x3 maximum test, list
// insert) into a chain of LIST_DEPTH list cells that all compare against the
// new corner in parallel and shift by one place, so one corner per clock enters
// the list. After the frame's last word req_ready stays low while that pipe drains
// and the ST_LOAD state sizes the run, then the list is shifted out through cell 0
// at one result word per clock while rsp_ready is high; req_ready returns in the
// cycle after the final result word is taken.
`include "corner_nms_top_k_select_macros.svh"
module corner_nms_top_k_select #(
   parameter int MAX_WIDTH = cnms_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = cnms_pkg::DEF_MAX_HEIGHT,
   parameter int LIST_DEPTH = cnms_pkg::DEF_LIST_DEPTH,
   parameter int RESPONSE_BITS = cnms_pkg::DEF_RESPONSE_BITS,
   localparam int COL_W = $clog2(MAX_WIDTH),
   localparam int ROW_W = $clog2(MAX_HEIGHT)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [cnms_pkg::VALUE_W-1:0]       req_response,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [COL_W-1:0]                   rsp_corner_x,
   output logic [ROW_W-1:0]                   rsp_corner_y,
   output logic [cnms_pkg::VALUE_W-1:0]       rsp_corner_response,
   output logic                               rsp_corner_valid,
   output logic                               rsp_list_truncated,
   output logic                               rsp_last_corner,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [cnms_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [cnms_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [cnms_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import cnms_pkg::*;

   localparam int CNT_W = $clog2(LIST_DEPTH + 1);
   localparam int DIM_W = ((COL_W > ROW_W) ? COL_W : ROW_W) > 12 ?
                          ((COL_W > ROW_W) ? COL_W : ROW_W) + 2 : 14;
   localparam logic [1:0] ST_RUN = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   // configuration registers
   logic [11:0] width_ff, height_ff;
   logic [31:0] thresh_ff;
   logic [7:0] margin_ff;
   logic [6:0] limit_ff;
   logic csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= RST_WIDTH;
         height_ff <= RST_HEIGHT;
         thresh_ff <= '0;
         margin_ff <= '0;
         limit_ff <= '0;
      end else if (csr_wr) begin
         case (csr_paddr[4:2])
            REG_WIDTH:  width_ff <= csr_pwdata[11:0];
            REG_HEIGHT: height_ff <= csr_pwdata[11:0];
            REG_THRESH: thresh_ff <= csr_pwdata;
            REG_MARGIN: margin_ff <= csr_pwdata[7:0];
            REG_LIMIT:  limit_ff <= csr_pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         REG_WIDTH:  csr_prdata = 32'(width_ff);
         REG_HEIGHT: csr_prdata = 32'(height_ff);
         REG_THRESH: csr_prdata = thresh_ff;
         REG_MARGIN: csr_prdata = 32'(margin_ff);
         REG_LIMIT:  csr_prdata = 32'(limit_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // effective frame size and margin
   logic [DIM_W-1:0] w_eff, h_eff, m_eff;
   always_comb begin
      if (width_ff < 12'd3) w_eff = DIM_W'(3);
      else if (DIM_W'(width_ff) > DIM_W'(MAX_WIDTH)) w_eff = DIM_W'(MAX_WIDTH);
      else w_eff = DIM_W'(width_ff);
      if (height_ff < 12'd3) h_eff = DIM_W'(3);
      else if (DIM_W'(height_ff) > DIM_W'(MAX_HEIGHT)) h_eff = DIM_W'(MAX_HEIGHT);
      else h_eff = DIM_W'(height_ff);
      m_eff = (margin_ff == 8'd0) ? DIM_W'(1) : DIM_W'(margin_ff);
   end

   // raster counters and thresholding
   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic busy_ff, accept, row_end, frame_end, eval;
   logic [DIM_W-1:0] c_ext, r_ext, x_ext, y_ext;
   logic signed [VALUE_W-1:0] raw, thr_value;

   assign req_ready = !busy_ff;
   assign accept = req_valid && req_ready;
   assign c_ext = DIM_W'(col_ff);
   assign r_ext = DIM_W'(row_ff);
   assign x_ext = c_ext - DIM_W'(1);
   assign y_ext = r_ext - DIM_W'(1);
   assign row_end = (c_ext + DIM_W'(1)) >= w_eff;
   assign frame_end = row_end && ((r_ext + DIM_W'(1)) >= h_eff);
   assign eval = (c_ext >= DIM_W'(2)) && (r_ext >= DIM_W'(2)) &&
                 (x_ext >= m_eff) && ((x_ext + m_eff) < w_eff) &&
                 (y_ext >= m_eff) && ((y_ext + m_eff) < h_eff);
   assign raw = $signed(req_response << (VALUE_W - RESPONSE_BITS)) >>>
                (VALUE_W - RESPONSE_BITS);
   assign thr_value = (raw > $signed(thresh_ff)) ? raw : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         if (row_end) begin
            col_ff <= '0;
            row_ff <= frame_end ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_ff <= col_ff + COL_W'(1);
         end
      end
   end

   // window and maximum test pipe
   logic cand_valid, cand_peak, cand_last;
   logic signed [VALUE_W-1:0] cand_value;
   logic [COL_W-1:0] cand_x;
   logic [ROW_W-1:0] cand_y;

   cnms_window #(
      .MAX_WIDTH(MAX_WIDTH),
      .COL_W(COL_W),
      .ROW_W(ROW_W)
   ) u_window (
      .clock(clock),
      .reset(reset),
      .in_valid(accept),
      .in_value(thr_value),
      .in_col(col_ff),
      .in_eval(eval),
      .in_x(x_ext[COL_W-1:0]),
      .in_y(y_ext[ROW_W-1:0]),
      .in_last(frame_end),
      .out_valid(cand_valid),
      .out_peak(cand_peak),
      .out_value(cand_value),
      .out_x(cand_x),
      .out_y(cand_y),
      .out_last(cand_last)
   );

   // list chain
   cell_cmd_type cmd;
   logic ge_w [LIST_DEPTH];
   logic valid_w [LIST_DEPTH];
   logic signed [VALUE_W-1:0] value_w [LIST_DEPTH];
   logic [COL_W-1:0] x_w [LIST_DEPTH];
   logic [ROW_W-1:0] y_w [LIST_DEPTH];
   logic [LIST_DEPTH-1:0] valid_vec;

   for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      logic pge, pvalid, nvalid;
      logic signed [VALUE_W-1:0] pvalue, nvalue;
      logic [COL_W-1:0] px, nx;
      logic [ROW_W-1:0] py, ny;
      if (i == 0) begin : g_head
         assign pge = 1'b1;
         assign pvalid = 1'b0;
         assign pvalue = '0;
         assign px = '0;
         assign py = '0;
      end else begin : g_body
         assign pge = ge_w[i-1];
         assign pvalid = valid_w[i-1];
         assign pvalue = value_w[i-1];
         assign px = x_w[i-1];
         assign py = y_w[i-1];
      end
      if (i == LIST_DEPTH - 1) begin : g_tail
         assign nvalid = 1'b0;
         assign nvalue = '0;
         assign nx = '0;
         assign ny = '0;
      end else begin : g_inner
         assign nvalid = valid_w[i+1];
         assign nvalue = value_w[i+1];
         assign nx = x_w[i+1];
         assign ny = y_w[i+1];
      end
      cnms_cell #(
         .COL_W(COL_W),
         .ROW_W(ROW_W)
      ) u_cell (
         .clock(clock),
         .reset(reset),
         .cmd(cmd),
         .new_value(cand_value),
         .new_x(cand_x),
         .new_y(cand_y),
         .prev_ge(pge),
         .prev_valid(pvalid),
         .prev_value(pvalue),
         .prev_x(px),
         .prev_y(py),
         .next_valid(nvalid),
         .next_value(nvalue),
         .next_x(nx),
         .next_y(ny),
         .ge(ge_w[i]),
         .valid(valid_w[i]),
         .value(value_w[i]),
         .x(x_w[i]),
         .y(y_w[i])
      );
      assign valid_vec[i] = valid_w[i];
   end

   // list sequencer
   logic [1:0] state_ff;
   logic [CNT_W-1:0] count_ff, emit_left_ff, lim, run_len;
   logic ovf_ff, empty_ff, out_fire, out_last;

   always_comb begin
      if (limit_ff == 7'd0 || {1'b0, limit_ff} > 8'(LIST_DEPTH)) lim = CNT_W'(LIST_DEPTH);
      else lim = CNT_W'(limit_ff);
      run_len = (count_ff < lim) ? count_ff : lim;
   end

   assign rsp_valid = (state_ff == ST_EMIT);
   assign out_fire = rsp_valid && rsp_ready;
   assign out_last = empty_ff || (emit_left_ff == CNT_W'(1));

   always_comb begin
      cmd.insert = (state_ff == ST_RUN) && cand_valid && cand_peak;
      cmd.pop = out_fire && !out_last;
      cmd.clear = out_fire && out_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         busy_ff <= 1'b0;
         count_ff <= '0;
         ovf_ff <= 1'b0;
         emit_left_ff <= '0;
         empty_ff <= 1'b0;
      end else begin
         if (accept && frame_end) begin
            busy_ff <= 1'b1;
         end
         case (state_ff)
            ST_RUN: begin
               if (cmd.insert) begin
                  if (count_ff == CNT_W'(LIST_DEPTH)) ovf_ff <= 1'b1;
                  else count_ff <= count_ff + CNT_W'(1);
               end
               if (cand_valid && cand_last) begin
                  state_ff <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               emit_left_ff <= run_len;
               empty_ff <= (run_len == '0);
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (out_fire) begin
                  if (out_last) begin
                     state_ff <= ST_RUN;
                     busy_ff <= 1'b0;
                     count_ff <= '0;
                     ovf_ff <= 1'b0;
                  end else begin
                     emit_left_ff <= emit_left_ff - CNT_W'(1);
                  end
               end
            end
            default: state_ff <= ST_RUN;
         endcase
      end
   end

   // result word from the head cell
   assign rsp_corner_valid = !empty_ff;
   assign rsp_corner_x = empty_ff ? '0 : x_w[0];
   assign rsp_corner_y = empty_ff ? '0 : y_w[0];
   assign rsp_corner_response = empty_ff ? '0 : value_w[0];
   assign rsp_list_truncated = !empty_ff && ovf_ff;
   assign rsp_last_corner = out_last;

   // the list drains by popping while emitting, so the count only tracks it while running
   `CNMS_ASSERT_ALWAYS(a_no_take_while_emit, !((state_ff != ST_RUN) && req_ready))
   `CNMS_ASSERT_ALWAYS(a_count_matches_cells, (state_ff != ST_RUN) || (CNT_W'($countones(valid_vec)) == count_ff))
   `CNMS_ASSERT_ALWAYS(a_count_bounded, count_ff <= CNT_W'(LIST_DEPTH))
   `CNMS_ASSERT_NEXT(a_ready_after_run, out_fire && out_last, req_ready && !rsp_valid)
endmodule

[rtl/cnms_window.sv]
// two line stores, 3x3 window and local maximum test
// depends on cnms_pkg
module cnms_window #(
   parameter int MAX_WIDTH = cnms_pkg::DEF_MAX_WIDTH,
   parameter int COL_W = 11,
   parameter int ROW_W = 11
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic signed [cnms_pkg::VALUE_W-1:0] in_value,
   input  logic [COL_W-1:0]                  in_col,
   input  logic                              in_eval,
   input  logic [COL_W-1:0]                  in_x,
   input  logic [ROW_W-1:0]                  in_y,
   input  logic                              in_last,
   output logic                              out_valid,
   output logic                              out_peak,
   output logic signed [cnms_pkg::VALUE_W-1:0] out_value,
   output logic [COL_W-1:0]                  out_x,
   output logic [ROW_W-1:0]                  out_y,
   output logic                              out_last
);
   import cnms_pkg::*;

   logic signed [VALUE_W-1:0] line1_mem [MAX_WIDTH];
   logic signed [VALUE_W-1:0] line2_mem [MAX_WIDTH];
   logic signed [VALUE_W-1:0] up1_ff, up2_ff, v1_ff;
   logic [COL_W-1:0] col1_ff, x1_ff, x2_ff;
   logic [ROW_W-1:0] y1_ff, y2_ff;
   logic valid1_ff, eval1_ff, last1_ff;
   logic valid2_ff, eval2_ff, last2_ff;
   logic signed [VALUE_W-1:0] win_ff [9];
   logic signed [VALUE_W-1:0] win_in [9];
   logic peak;
   logic signed [VALUE_W-1:0] ctr;

   // line store reads, newest row write, older row copy
   always_ff @(posedge clock) begin
      if (in_valid) begin
         up1_ff <= line1_mem[in_col];
         up2_ff <= line2_mem[in_col];
         line1_mem[in_col] <= in_value;
      end
      if (valid1_ff) begin
         line2_mem[col1_ff] <= up1_ff;
      end
   end

   // window shift, oldest column drops out
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         win_in[k*3] = win_ff[k*3+1];
         win_in[k*3+1] = win_ff[k*3+2];
      end
      win_in[2] = up2_ff;
      win_in[5] = up1_ff;
      win_in[8] = v1_ff;
   end

   always_ff @(posedge clock) begin
      v1_ff <= in_value;
      col1_ff <= in_col;
      x1_ff <= in_x;
      y1_ff <= in_y;
      eval1_ff <= in_eval;
      last1_ff <= in_last;
      if (valid1_ff) begin
         win_ff <= win_in;
      end
      x2_ff <= x1_ff;
      y2_ff <= y1_ff;
      eval2_ff <= eval1_ff;
      last2_ff <= last1_ff;
   end

   // centre nonzero, eval set, no smaller than any neighbour
   always_comb begin
      ctr = win_ff[4];
      peak = (ctr != '0) && eval2_ff;
      for (int k = 0; k < 9; k++) begin
         if (win_ff[k] > ctr) begin
            peak = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_peak <= peak;
      out_value <= ctr;
      out_x <= x2_ff;
      out_y <= y2_ff;
      out_last <= last2_ff;
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         out_valid <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
         out_valid <= valid2_ff;
      end
   end
endmodule

[rtl/cnms_cell.sv]
// one entry of the sorted corner list
// depends on cnms_pkg
module cnms_cell #(
   parameter int COL_W = 11,
   parameter int ROW_W = 11
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cnms_pkg::cell_cmd_type              cmd,
   input  logic signed [cnms_pkg::VALUE_W-1:0] new_value,
   input  logic [COL_W-1:0]                    new_x,
   input  logic [ROW_W-1:0]                    new_y,
   input  logic                                prev_ge,
   input  logic                                prev_valid,
   input  logic signed [cnms_pkg::VALUE_W-1:0] prev_value,
   input  logic [COL_W-1:0]                    prev_x,
   input  logic [ROW_W-1:0]                    prev_y,
   input  logic                                next_valid,
   input  logic signed [cnms_pkg::VALUE_W-1:0] next_value,
   input  logic [COL_W-1:0]                    next_x,
   input  logic [ROW_W-1:0]                    next_y,
   output logic                                ge,
   output logic                                valid,
   output logic signed [cnms_pkg::VALUE_W-1:0] value,
   output logic [COL_W-1:0]                    x,
   output logic [ROW_W-1:0]                    y
);
   import cnms_pkg::*;

   logic valid_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic [COL_W-1:0] x_ff;
   logic [ROW_W-1:0] y_ff;

   // kept entry wins ties, so equal values stay in raster order
   assign ge = valid_ff && (value_ff >= new_value);

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         valid_ff <= 1'b0;
      end else if (cmd.pop) begin
         valid_ff <= next_valid;
      end else if (cmd.insert && !ge) begin
         valid_ff <= prev_ge ? 1'b1 : prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pop) begin
         value_ff <= next_value;
         x_ff <= next_x;
         y_ff <= next_y;
      end else if (cmd.insert && !ge) begin
         if (prev_ge) begin
            value_ff <= new_value;
            x_ff <= new_x;
            y_ff <= new_y;
         end else begin
            value_ff <= prev_value;
            x_ff <= prev_x;
            y_ff <= prev_y;
         end
      end
   end

   assign valid = valid_ff;
   assign value = value_ff;
   assign x = x_ff;
   assign y = y_ff;
endmodule

[test/tb_corner_nms_top_k_select.sv]
// testbench for the corner suppression and top-k list block
// streams small frames of response words, predicts each frame's corner list in
// its own model of the window and list, and compares every result word; needs cnms_pkg
`timescale 1ns/1ps
`default_nettype none
module tb_corner_nms_top_k_select;
   timeunit 1ns;
   timeprecision 1ps;
   import cnms_pkg::*;

   localparam int MAXW = 2048;
   localparam int MAXH = 2048;
   localparam int DEPTH = 64;
   localparam int DRAIN_CYCLES = 12;

   typedef enum int {FILL_RANDOM, FILL_FULL, FILL_CONST, FILL_CHECKER, FILL_CENTRE} fill_mode_type;

   typedef struct packed {
      logic [10:0] x;
      logic [10:0] y;
      logic [31:0] resp;
      logic        valid;
      logic        trunc;
      logic        last;
   } corner_word_type;

   typedef struct {
      logic [11:0] width;
      logic [11:0] height;
      logic [31:0] thresh;
      logic [7:0]  mgn;
      logic [6:0]  lim;
      fill_mode_type mode;
      logic [31:0] fill;
      int unsigned frames;
      int unsigned hold;
      bit          typed;
      corner_word_type typed_word;
   } frame_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [31:0] req_response = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [10:0] rsp_corner_x, rsp_corner_y;
   logic [31:0] rsp_corner_response;
   logic rsp_corner_valid, rsp_list_truncated, rsp_last_corner;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   corner_nms_top_k_select dut (.*);

   always #5 clock = ~clock;

   // values settled mid cycle, used at the next rising edge
   logic s_req_ready, s_req_valid, s_rsp_valid, s_rsp_ready;
   logic [31:0] s_req_response;
   corner_word_type s_rsp;
   always @(negedge clock) begin
      s_req_ready = req_ready;
      s_req_valid = req_valid;
      s_req_response = req_response;
      s_rsp_valid = rsp_valid;
      s_rsp_ready = rsp_ready;
      s_rsp = '{rsp_corner_x, rsp_corner_y, rsp_corner_response, rsp_corner_valid,
                rsp_list_truncated, rsp_last_corner};
   end

   // predicted state of the block
   logic [11:0] cfg_width = 12'd640, cfg_height = 12'd480;
   logic signed [31:0] cfg_thresh = 0;
   logic [7:0] cfg_margin = 0;
   logic [6:0] cfg_limit = 0;
   int line_buf [2*MAXW];
   int win [9];
   int unsigned col_cnt = 0, row_cnt = 0;
   int kept_val [DEPTH];
   int unsigned kept_col [DEPTH], kept_row [DEPTH];
   int unsigned kept_n = 0;
   bit overflow_seen = 0;

   corner_word_type corner_q [$];
   bit typed_frame = 0;
   corner_word_type typed_word;
   int errors = 0;
   int idle_pct = 0, stall_pct = 0;
   int hold_cycles = 0;

   function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
      return v < 3 ? 3 : (v > hi ? hi : v);
   endfunction

   // sorted insert, ties keep raster order
   task automatic insert_corner(input int val, input int unsigned x, input int unsigned y);
      int unsigned p;
      p = 0;
      while (p < kept_n && kept_val[p] >= val) p++;
      if (kept_n >= DEPTH) begin
         overflow_seen = 1;
         if (p >= DEPTH) return;
      end else kept_n++;
      for (int unsigned i = kept_n - 1; i > p; i--) begin
         kept_val[i] = kept_val[i-1];
         kept_col[i] = kept_col[i-1];
         kept_row[i] = kept_row[i-1];
      end
      kept_val[p] = val;
      kept_col[p] = x;
      kept_row[p] = y;
   endtask

   // one accepted word through window, peak test and list; frame end queues results
   task automatic predict_word(input logic [31:0] word);
      int unsigned w, h, m, c, r, ci, x, y, lim, cnt;
      int v, up1, up2, ctr;
      bit peak;
      corner_word_type o;
      w = clamp_size(cfg_width, MAXW);
      h = clamp_size(cfg_height, MAXH);
      m = cfg_margin < 1 ? 1 : cfg_margin;
      c = col_cnt;
      r = row_cnt;
      ci = c < MAXW ? c : MAXW - 1;
      v = ($signed(word) > cfg_thresh) ? $signed(word) : 0;
      up2 = line_buf[MAXW + ci];
      up1 = line_buf[ci];
      for (int k = 0; k < 3; k++) begin
         win[k*3] = win[k*3+1];
         win[k*3+1] = win[k*3+2];
      end
      win[2] = up2;
      win[5] = up1;
      win[8] = v;
      line_buf[MAXW + ci] = up1;
      line_buf[ci] = v;
      if (c >= 2 && r >= 2) begin
         x = c - 1;
         y = r - 1;
         if (x >= m && x + m < w && y >= m && y + m < h) begin
            ctr = win[4];
            peak = ctr != 0;
            for (int k = 0; k < 9; k++) if (win[k] > ctr) peak = 0;
            if (peak) insert_corner(ctr, x, y);
         end
      end
      if (c + 1 >= w) begin
         col_cnt = 0;
         if (r + 1 >= h) begin
            lim = cfg_limit;
            if (lim == 0 || lim > DEPTH) lim = DEPTH;
            cnt = kept_n < lim ? kept_n : lim;
            if (typed_frame) corner_q = {corner_q, typed_word};
            else if (cnt == 0) begin
               o = '0;
               o.last = 1'b1;
               corner_q = {corner_q, o};
            end else for (int unsigned i = 0; i < cnt; i++) begin
               o.x = 11'(kept_col[i]);
               o.y = 11'(kept_row[i]);
               o.resp = 32'(kept_val[i]);
               o.valid = 1'b1;
               o.trunc = overflow_seen;
               o.last = (i + 1 == cnt);
               corner_q = {corner_q, o};
            end
            row_cnt = 0;
            kept_n = 0;
            overflow_seen = 0;
            foreach (win[k]) win[k] = 0;
         end else row_cnt = r + 1;
      end else col_cnt = c + 1;
   endtask

   // input side: prediction on every accepted word
   always @(posedge clock)
      if (!reset && s_req_valid && s_req_ready) predict_word(s_req_response);

   // result side: compare with oldest expectation
   always @(posedge clock)
      if (!reset && s_rsp_valid && s_rsp_ready) begin
         if (corner_q.size() == 0) begin
            $display("%0t: unexpected result word %p", $realtime, s_rsp);
            errors++;
         end else begin
            corner_word_type e;
            e = corner_q.pop_front();
            if (e.x !== s_rsp.x) begin
               $display("%0t: corner_x expected %0d got %0d", $realtime, e.x, s_rsp.x);
               errors++;
            end
            if (e.y !== s_rsp.y) begin
               $display("%0t: corner_y expected %0d got %0d", $realtime, e.y, s_rsp.y);
               errors++;
            end
            if (e.resp !== s_rsp.resp) begin
               $display("%0t: corner_response expected %h got %h", $realtime, e.resp,
                        s_rsp.resp);
               errors++;
            end
            if (e.valid !== s_rsp.valid) begin
               $display("%0t: corner_valid expected %b got %b", $realtime, e.valid,
                        s_rsp.valid);
               errors++;
            end
            if (e.trunc !== s_rsp.trunc) begin
               $display("%0t: list_truncated expected %b got %b", $realtime, e.trunc,
                        s_rsp.trunc);
               errors++;
            end
            if (e.last !== s_rsp.last) begin
               $display("%0t: last_corner expected %b got %b", $realtime, e.last,
                        s_rsp.last);
               errors++;
            end
         end
      end

   // receiver stalls, with an occasional long hold-off
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 0;
      end else rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] data);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      case (idx)
         REG_WIDTH:  cfg_width = data[11:0];
         REG_HEIGHT: cfg_height = data[11:0];
         REG_THRESH: cfg_thresh = data;
         REG_MARGIN: cfg_margin = data[7:0];
         REG_LIMIT:  cfg_limit = data[6:0];
         default: ;
      endcase
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
   endtask

   task automatic send_word(input logic [31:0] v);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_response <= v;
      do @(posedge clock); while (!s_req_ready);
   endtask

   // idle block: every result in, then let the pipe drain
   task automatic wait_drained();
      req_valid <= 0;
      @(posedge clock);
      while (corner_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // frames of one configuration sent back to back, then a full drain
   task automatic run_frame(input frame_row_type f);
      int unsigned w, h;
      logic [31:0] v;
      csr_write(REG_WIDTH, 32'(f.width));
      csr_write(REG_HEIGHT, 32'(f.height));
      csr_write(REG_THRESH, f.thresh);
      csr_write(REG_MARGIN, 32'(f.mgn));
      csr_write(REG_LIMIT, 32'(f.lim));
      typed_frame = f.typed;
      typed_word = f.typed_word;
      w = clamp_size(f.width, MAXW);
      h = clamp_size(f.height, MAXH);
      hold_cycles = int'(f.hold);
      for (int unsigned n = 0; n < f.frames; n++)
         for (int unsigned y = 0; y < h; y++)
            for (int unsigned x = 0; x < w; x++) begin
               case (f.mode)
                  FILL_RANDOM:  v = $urandom_range(12) - 2;
                  FILL_FULL:    v = $urandom;
                  FILL_CONST:   v = f.fill;
                  FILL_CHECKER: v = (x % 2 == 1 && y % 2 == 1) ? $urandom_range(1000, 40)
                                                              : $urandom_range(20);
                  default:      v = (x == 1 && y == 1) ? f.fill : 32'd0;
               endcase
               send_word(v);
            end
      wait_drained();
      typed_frame = 0;
   endtask

   // directed frames: single peak twice under a hold-off, threshold and size clamp,
   // wide margin, list overflow on equal values, full-range values, tall narrow frame
   frame_row_type directed [] = '{
      '{12'd3, 12'd3, 32'd0, 8'd0, 7'd0, FILL_CENTRE, 32'h7fff_ffff, 2, 60,
        1, '{11'd1, 11'd1, 32'h7fff_ffff, 1'b1, 1'b0, 1'b1}},
      '{12'd0, 12'd0, 32'h7fff_ffff, 8'd0, 7'd127, FILL_CONST, 32'h7fff_ffff, 1, 0,
        1, '{11'd0, 11'd0, 32'd0, 1'b0, 1'b0, 1'b1}},
      '{12'd3, 12'd3, 32'h8000_0000, 8'd255, 7'd64, FILL_CONST, 32'h8000_0000, 1, 0,
        1, '{11'd0, 11'd0, 32'd0, 1'b0, 1'b0, 1'b1}},
      '{12'd13, 12'd8, 32'd0, 8'd1, 7'd0, FILL_CONST, 32'd5, 1, 300, 0, '0},
      '{12'd6, 12'd6, 32'hffff_fff0, 8'd0, 7'd1, FILL_FULL, 32'd0, 1, 0, 0, '0},
      '{12'd3, 12'd8, 32'd5, 8'd0, 7'd2, FILL_RANDOM, 32'd0, 1, 0, 0, '0}
   };

   initial begin
      frame_row_type f;
      int sent;
      foreach (line_buf[i]) line_buf[i] = 0;
      foreach (win[i]) win[i] = 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (directed[i]) run_frame(directed[i]);

      // random frames over the idling phases
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = (ph == 1) ? 60 : (ph == 3) ? 19 : 0;
         stall_pct = (ph == 2) ? 60 : (ph == 3) ? 19 : 0;
         sent = 0;
         while (sent < 20) begin
            f.width = 12'($urandom_range(8, 3));
            f.height = 12'($urandom_range(8, 3));
            case ($urandom_range(9))
               0: f.thresh = $urandom;
               1: f.thresh = 32'h8000_0000;
               default: f.thresh = $urandom_range(6) - 2;
            endcase
            f.mgn = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(2));
            f.lim = ($urandom_range(3) == 0) ? 7'($urandom) : 7'($urandom_range(3));
            f.mode = ($urandom_range(3) == 0) ? FILL_FULL :
                     ($urandom_range(4) == 0) ? FILL_CHECKER : FILL_RANDOM;
            f.fill = 0;
            f.frames = 1;
            f.hold = 0;
            f.typed = 0;
            f.typed_word = '0;
            run_frame(f);
            sent += f.width * f.height;
         end
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   initial begin
      #5ms;
      $display("TEST FAILED");
      $finish;
   end
endmodule
`default_nettype wire

[sim.f]
+incdir+rtl
rtl/cnms_pkg.sv
rtl/cnms_window.sv
rtl/cnms_cell.sv
rtl/corner_nms_top_k_select.sv
test/tb_corner_nms_top_k_select.sv
